// ===== rtl/gre_pkg.sv =====
package gre_pkg;

    localparam int CELLS_PER_SIDE = 32;

    localparam int CMD_W     = 2;
    localparam int COORD_W   = 5;
    localparam int SIZE_W    = 6;
    localparam int BLOCK_W   = 16;
    localparam int COLOR_W   = 16;
    localparam int TEXTURE_W = 32;
    localparam int CELL_W    = BLOCK_W + COLOR_W + TEXTURE_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN   = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_EXTRACT = 2'd2
    } command_t;

    typedef struct packed {
        logic clr_start;
        logic clr_wr;
        logic in_wr;
        logic seek_adv;
        logic run_start;
        logic run_rd;
        logic run_inc;
        logic dn_start;
        logic dn_rd;
        logic dn_col;
        logic dn_row;
        logic er_start;
        logic er_wr;
        logic emit_hit;
        logic emit_none;
    } ctrl_t;

    typedef struct packed {
        logic clr_last;
        logic scan_end;
        logic data_nz;
        logic data_eq;
        logic run_end;
        logic down_end;
        logic col_last;
        logic erase_last;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/gre_in_if.sv =====
interface gre_in_if;
    logic                          valid;
    logic                          ready;
    logic [gre_pkg::CMD_W-1:0]     command;
    logic [gre_pkg::COORD_W-1:0]   cell_x;
    logic [gre_pkg::COORD_W-1:0]   cell_y;
    logic [gre_pkg::BLOCK_W-1:0]   block_word;
    logic [gre_pkg::COLOR_W-1:0]   color_word;
    logic [gre_pkg::TEXTURE_W-1:0] texture_word;

    modport source (
        output valid, command, cell_x, cell_y, block_word, color_word, texture_word,
        input  ready
    );
    modport sink (
        input  valid, command, cell_x, cell_y, block_word, color_word, texture_word,
        output ready
    );
endinterface

// ===== rtl/gre_out_if.sv =====
interface gre_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [gre_pkg::COORD_W-1:0]   face_x;
    logic [gre_pkg::COORD_W-1:0]   face_y;
    logic [gre_pkg::SIZE_W-1:0]    face_width;
    logic [gre_pkg::SIZE_W-1:0]    face_height;
    logic [gre_pkg::BLOCK_W-1:0]   face_block;
    logic [gre_pkg::COLOR_W-1:0]   face_color;
    logic [gre_pkg::TEXTURE_W-1:0] face_texture;

    modport source (
        output valid, found, face_x, face_y, face_width, face_height,
               face_block, face_color, face_texture,
        input  ready
    );
    modport sink (
        input  valid, found, face_x, face_y, face_width, face_height,
               face_block, face_color, face_texture,
        output ready
    );
endinterface

// ===== rtl/gre_ram.sv =====
module gre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gre_ctrl.sv =====
module gre_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [gre_pkg::CMD_W-1:0] in_command,
    output logic                      in_ready,
    input  gre_pkg::status_t          status,
    output gre_pkg::ctrl_t            ctrl
);

    typedef enum logic [10:0] {
        S_CLEAR     = 11'b000_0000_0001,
        S_IDLE      = 11'b000_0000_0010,
        S_SEEK_RD   = 11'b000_0000_0100,
        S_SEEK_CHK  = 11'b000_0000_1000,
        S_RUN_RD    = 11'b000_0001_0000,
        S_RUN_CHK   = 11'b000_0010_0000,
        S_DN_RD     = 11'b000_0100_0000,
        S_DN_CHK    = 11'b000_1000_0000,
        S_ERASE     = 11'b001_0000_0000,
        S_EMIT_HIT  = 11'b010_0000_0000,
        S_EMIT_NONE = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctrl.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_command)
                        gre_pkg::CMD_BEGIN:
                        begin
                            ctrl.clr_start = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        gre_pkg::CMD_WRITE:
                        begin
                            ctrl.in_wr = 1'b1;
                        end
                        gre_pkg::CMD_EXTRACT:
                        begin
                            state_next = S_SEEK_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEEK_RD:
            begin
                if (status.scan_end)
                begin
                    state_next = S_EMIT_NONE;
                end
                else
                begin
                    state_next = S_SEEK_CHK;
                end
            end
            S_SEEK_CHK:
            begin
                if (status.data_nz)
                begin
                    ctrl.run_start = 1'b1;
                    state_next     = S_RUN_RD;
                end
                else
                begin
                    ctrl.seek_adv = 1'b1;
                    state_next    = S_SEEK_RD;
                end
            end
            S_RUN_RD:
            begin
                if (status.run_end)
                begin
                    ctrl.dn_start = 1'b1;
                    state_next    = S_DN_RD;
                end
                else
                begin
                    ctrl.run_rd = 1'b1;
                    state_next  = S_RUN_CHK;
                end
            end
            S_RUN_CHK:
            begin
                if (status.data_eq)
                begin
                    ctrl.run_inc = 1'b1;
                    state_next   = S_RUN_RD;
                end
                else
                begin
                    ctrl.dn_start = 1'b1;
                    state_next    = S_DN_RD;
                end
            end
            S_DN_RD:
            begin
                if (status.down_end)
                begin
                    ctrl.er_start = 1'b1;
                    state_next    = S_ERASE;
                end
                else
                begin
                    ctrl.dn_rd = 1'b1;
                    state_next = S_DN_CHK;
                end
            end
            S_DN_CHK:
            begin
                priority if (!status.data_eq)
                begin
                    ctrl.er_start = 1'b1;
                    state_next    = S_ERASE;
                end
                else if (status.col_last)
                begin
                    ctrl.dn_row = 1'b1;
                    state_next  = S_DN_RD;
                end
                else
                begin
                    ctrl.dn_col = 1'b1;
                    state_next  = S_DN_RD;
                end
            end
            S_ERASE:
            begin
                ctrl.er_wr = 1'b1;
                if (status.erase_last)
                begin
                    state_next = S_EMIT_HIT;
                end
            end
            S_EMIT_HIT:
            begin
                if (status.out_free)
                begin
                    ctrl.emit_hit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EMIT_NONE:
            begin
                if (status.out_free)
                begin
                    ctrl.emit_none = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/gre_datapath.sv =====
module gre_datapath #(
    parameter int CELLS_PER_SIDE = gre_pkg::CELLS_PER_SIDE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gre_pkg::ctrl_t                ctrl,
    output gre_pkg::status_t              status,
    input  logic [gre_pkg::COORD_W-1:0]   cell_x,
    input  logic [gre_pkg::COORD_W-1:0]   cell_y,
    input  logic [gre_pkg::BLOCK_W-1:0]   block_word,
    input  logic [gre_pkg::COLOR_W-1:0]   color_word,
    input  logic [gre_pkg::TEXTURE_W-1:0] texture_word,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          found,
    output logic [gre_pkg::COORD_W-1:0]   face_x,
    output logic [gre_pkg::COORD_W-1:0]   face_y,
    output logic [gre_pkg::SIZE_W-1:0]    face_width,
    output logic [gre_pkg::SIZE_W-1:0]    face_height,
    output logic [gre_pkg::BLOCK_W-1:0]   face_block,
    output logic [gre_pkg::COLOR_W-1:0]   face_color,
    output logic [gre_pkg::TEXTURE_W-1:0] face_texture
);

    localparam int N     = CELLS_PER_SIDE;
    localparam int DEPTH = N * N;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(N + 1);
    localparam int XW    = gre_pkg::COORD_W + 1;
    localparam int BW    = gre_pkg::BLOCK_W;
    localparam int LW    = gre_pkg::COLOR_W;
    localparam int CELL  = gre_pkg::CELL_W;

    localparam logic [CW-1:0] SIDE_C   = CW'(N);
    localparam logic [CW-1:0] ONE_C    = CW'(1);
    localparam logic [AW-1:0] SIDE_A   = AW'(N);
    localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);
    localparam logic [XW-1:0] SIDE_X   = XW'(N);

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return AW'(y) * SIDE_A + AW'(x);
    endfunction

    logic [AW-1:0]   clr_reg;
    logic [CW-1:0]   sx_reg;
    logic [CW-1:0]   sy_reg;
    logic [CW-1:0]   w_reg;
    logic [CW-1:0]   h_reg;
    logic [CW-1:0]   i_reg;
    logic [CW-1:0]   j_reg;
    logic [CELL-1:0] word_reg;

    logic                          out_valid_reg;
    logic                          found_reg;
    logic [gre_pkg::COORD_W-1:0]   face_x_reg;
    logic [gre_pkg::COORD_W-1:0]   face_y_reg;
    logic [gre_pkg::SIZE_W-1:0]    face_width_reg;
    logic [gre_pkg::SIZE_W-1:0]    face_height_reg;
    logic [CELL-1:0]               face_word_reg;

    logic [CW-1:0]   sx_inc;
    logic [CW-1:0]   run_x;
    logic [CW-1:0]   col_x;
    logic [CW-1:0]   row_y;
    logic [CW-1:0]   er_y;
    logic [CW-1:0]   i_inc;
    logic [CW-1:0]   j_inc;
    logic            in_range;
    logic [CELL-1:0] in_word;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [CELL-1:0] wdata;
    logic [AW-1:0]   raddr;
    logic [CELL-1:0] rdata;

    assign sx_inc   = sx_reg + ONE_C;
    assign run_x    = sx_reg + w_reg;
    assign col_x    = sx_reg + i_reg;
    assign row_y    = sy_reg + h_reg;
    assign er_y     = sy_reg + j_reg;
    assign i_inc    = i_reg + ONE_C;
    assign j_inc    = j_reg + ONE_C;
    assign in_range = ({1'b0, cell_x} < SIDE_X) && ({1'b0, cell_y} < SIDE_X);
    assign in_word  = {texture_word, color_word, block_word};

    assign we    = ctrl.clr_wr || ctrl.er_wr || (ctrl.in_wr && in_range);
    assign waddr = ctrl.clr_wr ? clr_reg :
                   ctrl.er_wr  ? addr_of(col_x, er_y) :
                                 addr_of(CW'(cell_x), CW'(cell_y));
    assign wdata = ctrl.in_wr ? in_word : '0;

    assign raddr = ctrl.run_rd ? addr_of(run_x, sy_reg) :
                   ctrl.dn_rd  ? addr_of(col_x, row_y) :
                                 addr_of(sx_reg, sy_reg);

    gre_ram #(
        .WIDTH (CELL),
        .DEPTH (DEPTH)
    ) u_mask (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            w_reg   <= '0;
            h_reg   <= '0;
            i_reg   <= '0;
            j_reg   <= '0;
        end
        else
        begin
            if (ctrl.clr_start)
            begin
                clr_reg <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
            end
            else if (ctrl.clr_wr)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (ctrl.seek_adv)
            begin
                if (sx_inc == SIDE_C)
                begin
                    sx_reg <= '0;
                    sy_reg <= sy_reg + ONE_C;
                end
                else
                begin
                    sx_reg <= sx_inc;
                end
            end
            if (ctrl.run_start)
            begin
                w_reg <= ONE_C;
            end
            else if (ctrl.run_inc)
            begin
                w_reg <= w_reg + ONE_C;
            end
            if (ctrl.dn_start)
            begin
                h_reg <= ONE_C;
                i_reg <= '0;
            end
            else if (ctrl.dn_row)
            begin
                h_reg <= h_reg + ONE_C;
                i_reg <= '0;
            end
            else if (ctrl.dn_col)
            begin
                i_reg <= i_inc;
            end
            else if (ctrl.er_start)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            else if (ctrl.er_wr)
            begin
                if (i_inc == w_reg)
                begin
                    i_reg <= '0;
                    j_reg <= j_inc;
                end
                else
                begin
                    i_reg <= i_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.run_start)
        begin
            word_reg <= rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit_hit || ctrl.emit_none)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit_hit)
        begin
            found_reg       <= 1'b1;
            face_x_reg      <= gre_pkg::COORD_W'(sx_reg);
            face_y_reg      <= gre_pkg::COORD_W'(sy_reg);
            face_width_reg  <= gre_pkg::SIZE_W'(w_reg);
            face_height_reg <= gre_pkg::SIZE_W'(h_reg);
            face_word_reg   <= word_reg;
        end
        else if (ctrl.emit_none)
        begin
            found_reg       <= 1'b0;
            face_x_reg      <= '0;
            face_y_reg      <= '0;
            face_width_reg  <= '0;
            face_height_reg <= '0;
            face_word_reg   <= '0;
        end
    end

    assign status.clr_last   = (clr_reg == LAST_A);
    assign status.scan_end   = (sy_reg == SIDE_C);
    assign status.data_nz    = (rdata != '0);
    assign status.data_eq    = (rdata == word_reg);
    assign status.run_end    = (run_x == SIDE_C);
    assign status.down_end   = (row_y == SIDE_C);
    assign status.col_last   = (i_inc == w_reg);
    assign status.erase_last = (i_inc == w_reg) && (j_inc == h_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign face_x       = face_x_reg;
    assign face_y       = face_y_reg;
    assign face_width   = face_width_reg;
    assign face_height  = face_height_reg;
    assign face_block   = face_word_reg[BW-1:0];
    assign face_color   = face_word_reg[BW+LW-1:BW];
    assign face_texture = face_word_reg[CELL-1:BW+LW];

endmodule

// ===== rtl/greedy_rectangle_extractor.sv =====
// Write and unused command transfers stay in idle; a begin transfer starts a clear pass.
// Extract scans in row order for the first nonzero cell, grows a run of equal cells along
// its row, then rows down while the run matches, erases it and loads the result register
// (registered mask RAM read); a scan that finds no nonzero cell emits a not-found result.
// The result waits in an output register; the next item is taken while it waits. Reset
// (async, active low) and every begin transfer run a clear pass with no item accepted.
module greedy_rectangle_extractor #(
    parameter int CELLS_PER_SIDE = gre_pkg::CELLS_PER_SIDE
) (
    input  logic       clk,
    input  logic       rst_n,
    gre_in_if.sink     items,
    gre_out_if.source  faces
);

    gre_pkg::ctrl_t   ctrl;
    gre_pkg::status_t status;

    gre_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (items.valid),
        .in_command (items.command),
        .in_ready   (items.ready),
        .status     (status),
        .ctrl       (ctrl)
    );

    gre_datapath #(
        .CELLS_PER_SIDE (CELLS_PER_SIDE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .cell_x       (items.cell_x),
        .cell_y       (items.cell_y),
        .block_word   (items.block_word),
        .color_word   (items.color_word),
        .texture_word (items.texture_word),
        .out_ready    (faces.ready),
        .out_valid    (faces.valid),
        .found        (faces.found),
        .face_x       (faces.face_x),
        .face_y       (faces.face_y),
        .face_width   (faces.face_width),
        .face_height  (faces.face_height),
        .face_block   (faces.face_block),
        .face_color   (faces.face_color),
        .face_texture (faces.face_texture)
    );

endmodule
